### hdl/hfs_pkg.sv
`default_nettype none
package hfs_pkg;

    localparam int PROB_FRAC_BITS = 31;
    localparam int PROB_W = 32;
    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

    localparam int IDX_W = 6;
    localparam int FUNC_W = 2;
    localparam int STATE_W = 4;
    localparam int SYM_W = 2;
    localparam int CFG_W = 5;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_SYMBOL = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        DP_IDLE,
        DP_MAC,
        DP_COPY,
        DP_SUM
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_DRAIN0,
        ST_MAC_DRAIN1,
        ST_COPY,
        ST_COPY_DRAIN,
        ST_SUM,
        ST_SUM_DRAIN,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic             take;
        logic             init;
        dp_op_t           op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first;
        logic             last;
        logic             trim;
        logic [IDX_W-1:0] last_idx;
        logic             clr_sum;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

### hdl/hfs_ctrl.sv
`default_nettype none
module hfs_ctrl #(
    parameter int MAX_STATES = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [hfs_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [hfs_pkg::FUNC_W-1:0] s_tuser,
    output hfs_pkg::dp_cmd_t               cmd,
    input  wire hfs_pkg::dp_status_t       status
);

    localparam int SW = $clog2(MAX_STATES);

    hfs_pkg::ctrl_state_t state_reg, state_next;
    logic [hfs_pkg::CFG_W-1:0] num_states_reg;
    logic [SW-1:0] row_reg, row_next;
    logic [SW-1:0] col_reg, col_next;
    logic [SW-1:0] last_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hfs_pkg::ST_IDLE;
            num_states_reg <= hfs_pkg::CFG_W'(16);
            row_reg        <= '0;
            col_reg        <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_wr_en) begin
                num_states_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        if (num_states_reg == '0) begin
            last_idx = '0;
        end else if (int'(num_states_reg) > MAX_STATES) begin
            last_idx = SW'(MAX_STATES - 1);
        end else begin
            last_idx = SW'(num_states_reg - hfs_pkg::CFG_W'(1));
        end
    end

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.op       = hfs_pkg::DP_IDLE;
        cmd.row      = hfs_pkg::IDX_W'(row_reg);
        cmd.col      = hfs_pkg::IDX_W'(col_reg);
        cmd.first    = (row_reg == '0);
        cmd.last     = (row_reg == last_idx);
        cmd.last_idx = hfs_pkg::IDX_W'(last_idx);
        unique case (state_reg)
            hfs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                row_next = '0;
                col_next = '0;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    unique case (hfs_pkg::func_t'(s_tuser))
                        hfs_pkg::FUNC_START: begin
                            cmd.init   = 1'b1;
                            state_next = hfs_pkg::ST_SUM;
                        end
                        hfs_pkg::FUNC_SYMBOL: begin
                            state_next = hfs_pkg::ST_MAC;
                        end
                        hfs_pkg::FUNC_LOAD,
                        hfs_pkg::FUNC_NONE: begin
                            state_next = hfs_pkg::ST_SUM;
                        end
                    endcase
                end
            end
            hfs_pkg::ST_MAC: begin
                cmd.op = hfs_pkg::DP_MAC;
                if (row_reg == last_idx) begin
                    row_next = '0;
                    if (col_reg == last_idx) begin
                        col_next   = '0;
                        state_next = hfs_pkg::ST_MAC_DRAIN0;
                    end else begin
                        col_next = col_reg + SW'(1);
                    end
                end else begin
                    row_next = row_reg + SW'(1);
                end
            end
            hfs_pkg::ST_MAC_DRAIN0: begin
                state_next = hfs_pkg::ST_MAC_DRAIN1;
            end
            hfs_pkg::ST_MAC_DRAIN1: begin
                state_next = hfs_pkg::ST_COPY;
            end
            hfs_pkg::ST_COPY: begin
                cmd.op   = hfs_pkg::DP_COPY;
                cmd.trim = (col_reg == '0);
                if (col_reg == last_idx) begin
                    col_next   = '0;
                    state_next = hfs_pkg::ST_COPY_DRAIN;
                end else begin
                    col_next = col_reg + SW'(1);
                end
            end
            hfs_pkg::ST_COPY_DRAIN: begin
                state_next = hfs_pkg::ST_SUM;
            end
            hfs_pkg::ST_SUM: begin
                cmd.op      = hfs_pkg::DP_SUM;
                cmd.clr_sum = (col_reg == '0);
                if (col_reg == last_idx) begin
                    col_next   = '0;
                    state_next = hfs_pkg::ST_SUM_DRAIN;
                end else begin
                    col_next = col_reg + SW'(1);
                end
            end
            hfs_pkg::ST_SUM_DRAIN: begin
                state_next = hfs_pkg::ST_OUT;
            end
            hfs_pkg::ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = hfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/hfs_datapath.sv
`default_nettype none
module hfs_datapath #(
    parameter int MAX_STATES = 16,
    parameter int ALPHABET   = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [hfs_pkg::FUNC_W-1:0]    s_tuser,
    input  wire logic [hfs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire hfs_pkg::dp_cmd_t              cmd,
    output hfs_pkg::dp_status_t                status,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hfs_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SW        = $clog2(MAX_STATES);
    localparam int AW        = $clog2(ALPHABET);
    localparam int TAW       = 2 * SW + AW;
    localparam int TAB_DEPTH = 1 << TAW;
    localparam int PW        = hfs_pkg::PROB_W;

    function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, hfs_pkg::PROB_ONE}) ? hfs_pkg::PROB_ONE : s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] fx_mul(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [2*PW-1:0] p;
        logic [2*PW-1:0] r;
        p = {{PW{1'b0}}, a} * {{PW{1'b0}}, b};
        r = p >> hfs_pkg::PROB_FRAC_BITS;
        return (r > (2*PW)'(hfs_pkg::PROB_ONE)) ? hfs_pkg::PROB_ONE : r[PW-1:0];
    endfunction

    logic [hfs_pkg::STATE_W-1:0] in_from;
    logic [hfs_pkg::STATE_W-1:0] in_to;
    logic [hfs_pkg::SYM_W-1:0]   in_sym;
    logic [PW-1:0]               in_val;
    logic [PW-1:0]               in_val_clamped;
    logic                        load_ok;

    logic [hfs_pkg::SYM_W-1:0] sym_reg;
    logic                      sym_ok;

    logic [PW-1:0] tab_mem [TAB_DEPTH];
    logic [PW-1:0] fwd_mem [MAX_STATES];
    logic [PW-1:0] nxt_mem [MAX_STATES];
    logic [MAX_STATES-1:0] fwd_vld_reg;

    logic [SW-1:0] fwd_idx;
    logic [SW-1:0] row_idx;
    logic [SW-1:0] col_idx;

    logic [PW-1:0]    tab_rd_reg;
    logic [PW-1:0]    fwd_rd_reg;
    logic [PW-1:0]    nxt_rd_reg;
    logic             vld1_reg;
    logic             head1_reg;
    hfs_pkg::dp_op_t  op1_reg;
    logic [SW-1:0]    col1_reg;
    logic             first1_reg;
    logic             last1_reg;
    logic [PW-1:0]    fwd_val1;
    logic [PW-1:0]    prod_next;

    logic          mac2_reg;
    logic [SW-1:0] col2_reg;
    logic          first2_reg;
    logic          last2_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] acc_next;

    logic [PW-1:0] sum_reg;
    logic          zero_reg;
    logic          m_tvalid_reg;
    logic [PW-1:0] out_sum_reg;
    logic          out_zero_reg;

    assign in_from = s_tdata[3:0];
    assign in_to   = s_tdata[7:4];
    assign in_sym  = s_tdata[9:8];
    assign in_val  = s_tdata[41:10];
    assign in_val_clamped = (in_val > hfs_pkg::PROB_ONE) ? hfs_pkg::PROB_ONE : in_val;
    assign load_ok = (hfs_pkg::func_t'(s_tuser) == hfs_pkg::FUNC_LOAD)
                     && (int'(in_from) < MAX_STATES) && (int'(in_to) < MAX_STATES)
                     && (int'(in_sym) < ALPHABET);

    assign sym_ok  = (int'(sym_reg) < ALPHABET);
    assign row_idx = cmd.row[SW-1:0];
    assign col_idx = cmd.col[SW-1:0];
    assign fwd_idx = (cmd.op == hfs_pkg::DP_MAC) ? row_idx : col_idx;

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sym_reg <= in_sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && load_ok) begin
            tab_mem[{SW'(in_from), SW'(in_to), AW'(in_sym)}] <= in_val_clamped;
        end
        tab_rd_reg <= tab_mem[{row_idx, col_idx, AW'(sym_reg)}];
    end

    always_ff @(posedge aclk) begin
        if (op1_reg == hfs_pkg::DP_COPY) begin
            fwd_mem[col1_reg] <= nxt_rd_reg;
        end
        fwd_rd_reg <= fwd_mem[fwd_idx];
    end

    always_ff @(posedge aclk) begin
        if (mac2_reg && last2_reg) begin
            nxt_mem[col2_reg] <= acc_next;
        end
        nxt_rd_reg <= nxt_mem[col_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_vld_reg <= '0;
        end else if (cmd.init) begin
            fwd_vld_reg <= '0;
        end else begin
            for (int i = 0; i < MAX_STATES; i++) begin
                if (cmd.trim && (i > int'(cmd.last_idx))) begin
                    fwd_vld_reg[i] <= 1'b0;
                end
            end
            if (op1_reg == hfs_pkg::DP_COPY) begin
                fwd_vld_reg[col1_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        vld1_reg   <= fwd_vld_reg[fwd_idx];
        head1_reg  <= (fwd_idx == '0);
        col1_reg   <= col_idx;
        first1_reg <= cmd.first;
        last1_reg  <= cmd.last;
        if (!aresetn) begin
            op1_reg <= hfs_pkg::DP_IDLE;
        end else begin
            op1_reg <= cmd.op;
        end
    end

    always_comb begin
        if (vld1_reg) begin
            fwd_val1 = fwd_rd_reg;
        end else if (head1_reg) begin
            fwd_val1 = hfs_pkg::PROB_ONE;
        end else begin
            fwd_val1 = '0;
        end
        prod_next = sym_ok ? fx_mul(fwd_val1, tab_rd_reg) : '0;
        acc_next  = sat_add(first2_reg ? '0 : acc_reg, prod_reg);
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        col2_reg   <= col1_reg;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        if (!aresetn) begin
            mac2_reg <= 1'b0;
            acc_reg  <= '0;
        end else begin
            mac2_reg <= (op1_reg == hfs_pkg::DP_MAC);
            if (mac2_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            zero_reg <= 1'b1;
        end else if (cmd.clr_sum) begin
            sum_reg  <= '0;
            zero_reg <= 1'b1;
        end else if (op1_reg == hfs_pkg::DP_SUM) begin
            sum_reg  <= sat_add(sum_reg, fwd_val1);
            zero_reg <= zero_reg & (fwd_val1 == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sum_reg  <= sum_reg;
            out_zero_reg <= zero_reg;
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.out_busy = m_tvalid_reg & ~m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(hfs_pkg::M_TDATA_W - PW - 1){1'b0}}, out_zero_reg, out_sum_reg};

endmodule
`default_nettype wire

### hdl/hmm_forward_step.sv
// One step of the forward algorithm of a hidden Markov model with a joint
// transition-emission table per (source state, target state, symbol), values
// unsigned Q1.31, products truncated, sums saturated at 1.0. Every request
// gives exactly one result with the saturated sum of the forward vector over
// the states in use and an all-zero flag. A symbol request is handled by the
// single shared multiply-accumulate unit that visits every state pair once,
// followed by a copy of the new vector and a summing pass; load, start and
// unused requests run only the summing pass. A new request is accepted while
// the previous result still waits on the output. The probability table is not
// cleared at reset; reading an entry that was never loaded gives an undefined
// result.
`default_nettype none
module hmm_forward_step #(
    parameter int MAX_STATES = 16,
    parameter int ALPHABET   = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [hfs_pkg::CFG_W-1:0]     cfg_wr_data,  // num_states
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hfs_pkg::S_TDATA_W-1:0] s_tdata,      // from_state, to_state, symbol, prob_value
    input  wire logic [hfs_pkg::FUNC_W-1:0]    s_tuser,      // func
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hfs_pkg::M_TDATA_W-1:0]      m_tdata       // seq_prob, all_zero
);

    hfs_pkg::dp_cmd_t    cmd;
    hfs_pkg::dp_status_t status;

    hfs_ctrl #(
        .MAX_STATES(MAX_STATES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .cmd        (cmd),
        .status     (status)
    );

    hfs_datapath #(
        .MAX_STATES(MAX_STATES),
        .ALPHABET  (ALPHABET)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire

### hdl/hfs_checker.sv
`default_nettype none
module hfs_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [hfs_pkg::M_TDATA_W-1:0] m_tdata
);

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[hfs_pkg::PROB_W-1:0] <= hfs_pkg::PROB_ONE)
        else $error("sequence probability above one");

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[hfs_pkg::PROB_W] == (m_tdata[hfs_pkg::PROB_W-1:0] == '0))
        else $error("all-zero flag disagrees with sum");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[hfs_pkg::M_TDATA_W-1:hfs_pkg::PROB_W+1] == '0)
        else $error("result padding not zero");

endmodule

bind hmm_forward_step hfs_checker u_hfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire
